FILE: hdl/xtt_pkg.sv
`timescale 1ns / 1ps

package xtt_pkg;

  localparam int NAME_MAX_DEF  = 32;
  localparam int CMD_DEPTH_DEF = 4;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_QM  = 8'h3F;
  localparam logic [7:0] CH_SL  = 8'h2F;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [3:0] {
    MODE_SEARCH,
    MODE_TAG_OPEN,
    MODE_HDR,
    MODE_HDR_AFTER,
    MODE_NAME,
    MODE_ATTR,
    MODE_CLOSE,
    MODE_VALUE_LEAD,
    MODE_VALUE
  } mode_e;

  typedef enum logic [2:0] {
    EV_START_BYTE = 3'd0,
    EV_START_END  = 3'd1,
    EV_STOP_BYTE  = 3'd2,
    EV_STOP_END   = 3'd3,
    EV_VALUE_BYTE = 3'd4,
    EV_VALUE_END  = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_E0,
    PH_E1,
    PH_REPLAY
  } phase_e;

  // up to two plain events, then an optional replay of the stored start name
  typedef struct packed {
    logic       e0_v;
    event_e     e0_ev;
    logic [7:0] e0_byte;
    logic       e1_v;
    event_e     e1_ev;
    logic [7:0] e1_byte;
    logic       replay;
    logic       clr;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {CH_SP, CH_TAB, CH_LF};
  endfunction

endpackage

FILE: hdl/xml_tag_tokenizer.sv
// a byte's command goes via the queue and the command register into the result register
// throughput: one byte per cycle while the queue is not full, one result per cycle while
//   the receiver pops; an empty-tag replay of n name bytes gives n+1 results
// input stalls only when the command queue between front and back is full
// reset: asynchronous, active low; clears scan state, queue and result register,
//   the name memory is not cleared
`timescale 1ns / 1ps

module xml_tag_tokenizer #(
  parameter int NAME_MAX  = xtt_pkg::NAME_MAX_DEF,
  parameter int CMD_DEPTH = xtt_pkg::CMD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_res_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic          accept;
  logic          q_push, q_pop, q_empty;
  xtt_pkg::cmd_t cmd_w, head_w;

  assign accept = push && !full;

  xtt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .byte_i     (in_byte_i),
    .eod_i      (end_of_data_i),
    .cmd_push_o (q_push),
    .cmd_o      (cmd_w)
  );

  xtt_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_w),
    .pop_i   (q_pop),
    .data_o  (head_w),
    .full_o  (full),
    .empty_o (q_empty)
  );

  xtt_back #(
    .NAME_MAX (NAME_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_w),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .event_res_o (event_res_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  a_cmd_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (cmd_w.e0_v || cmd_w.replay))
    else $error("empty command queued");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && cmd_w.e1_v |-> cmd_w.e0_v)
    else $error("second event without first");

  a_replay_after_start_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && cmd_w.replay && cmd_w.e0_v |-> (cmd_w.e0_ev == xtt_pkg::EV_START_END))
    else $error("replay not preceded by start end");

  a_no_pop_when_empty_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command taken from empty queue");

endmodule

FILE: hdl/xtt_cmd_fifo.sv
`timescale 1ns / 1ps

module xtt_cmd_fifo #(
  parameter int DEPTH = xtt_pkg::CMD_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xtt_pkg::cmd_t data_i,
  input  logic          pop_i,
  output xtt_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xtt_pkg::cmd_t entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/xtt_front.sv
`timescale 1ns / 1ps

module xtt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    byte_i,
  input  logic          eod_i,
  output logic          cmd_push_o,
  output xtt_pkg::cmd_t cmd_o
);

  xtt_pkg::mode_e mode_q, mode_d, mode_nx;
  logic           pend_q, pend_d;
  logic [7:0]     quote_q, quote_d;
  logic [7:0]     prev_q, prev_d;

  // next state
  always_comb begin
    logic       pv;
    logic [7:0] qc;
    pv      = 1'b0;
    qc      = '0;
    mode_nx = mode_q;
    pend_d  = pend_q;
    quote_d = quote_q;
    prev_d  = prev_q;
    if (acc_i) begin
      prev_d = byte_i;
      case (mode_q)
        xtt_pkg::MODE_TAG_OPEN, xtt_pkg::MODE_NAME: begin
          pv      = (mode_q == xtt_pkg::MODE_NAME) && pend_q;
          qc      = (mode_q == xtt_pkg::MODE_NAME) ? quote_q : '0;
          pend_d  = pv;
          quote_d = qc;
          if (mode_q == xtt_pkg::MODE_TAG_OPEN && byte_i == xtt_pkg::CH_QM) begin
            mode_nx = xtt_pkg::MODE_HDR;
          end else if (mode_q == xtt_pkg::MODE_TAG_OPEN && byte_i == xtt_pkg::CH_SL) begin
            mode_nx = xtt_pkg::MODE_CLOSE;
          end else begin
            mode_nx = xtt_pkg::MODE_NAME;
            if (qc != '0) begin
              if (byte_i == qc) begin
                quote_d = '0;
              end
            end else if (byte_i == xtt_pkg::CH_GT) begin
              mode_nx = pv ? xtt_pkg::MODE_SEARCH : xtt_pkg::MODE_VALUE_LEAD;
              pend_d  = 1'b0;
            end else begin
              pend_d = 1'b0;
              if (xtt_pkg::is_ws(byte_i)) begin
                mode_nx = xtt_pkg::MODE_ATTR;
              end else if (byte_i == xtt_pkg::CH_SL) begin
                pend_d = 1'b1;
              end else if (byte_i inside {xtt_pkg::CH_SQ, xtt_pkg::CH_DQ}) begin
                quote_d = byte_i;
              end
            end
          end
        end
        xtt_pkg::MODE_HDR: begin
          if (byte_i == xtt_pkg::CH_QM) begin
            mode_nx = xtt_pkg::MODE_HDR_AFTER;
          end
        end
        xtt_pkg::MODE_HDR_AFTER: begin
          mode_nx = xtt_pkg::MODE_SEARCH;
        end
        xtt_pkg::MODE_ATTR: begin
          if (byte_i == xtt_pkg::CH_GT) begin
            mode_nx = (prev_q == xtt_pkg::CH_SL) ? xtt_pkg::MODE_SEARCH
                                                 : xtt_pkg::MODE_VALUE_LEAD;
          end
        end
        xtt_pkg::MODE_CLOSE: begin
          if (byte_i == xtt_pkg::CH_GT) begin
            mode_nx = (prev_q != xtt_pkg::CH_SL) ? xtt_pkg::MODE_VALUE_LEAD
                                                 : xtt_pkg::MODE_SEARCH;
          end
        end
        xtt_pkg::MODE_VALUE_LEAD: begin
          if (byte_i == xtt_pkg::CH_LT) begin
            mode_nx = xtt_pkg::MODE_TAG_OPEN;
          end else if (!xtt_pkg::is_ws(byte_i)) begin
            mode_nx = xtt_pkg::MODE_VALUE;
          end
        end
        xtt_pkg::MODE_VALUE: begin
          if (byte_i == xtt_pkg::CH_LT) begin
            mode_nx = xtt_pkg::MODE_TAG_OPEN;
          end
        end
        default: begin
          mode_nx = xtt_pkg::MODE_SEARCH;
          if (byte_i == xtt_pkg::CH_LT) begin
            mode_nx = xtt_pkg::MODE_TAG_OPEN;
          end else if (byte_i == xtt_pkg::CH_GT && prev_q != xtt_pkg::CH_SL) begin
            mode_nx = xtt_pkg::MODE_VALUE_LEAD;
          end
        end
      endcase
    end
    mode_d = mode_nx;
    if (acc_i && eod_i) begin
      mode_d  = xtt_pkg::MODE_SEARCH;
      pend_d  = 1'b0;
      quote_d = '0;
      prev_d  = '0;
    end
  end

  // command for the back end
  always_comb begin
    logic              pv;
    logic [7:0]        qc;
    logic              sa_v, sb_v;
    xtt_pkg::event_e   sb_ev;
    logic [7:0]        sb_b;
    pv     = 1'b0;
    qc     = '0;
    sa_v   = 1'b0;
    sb_v   = 1'b0;
    sb_ev  = xtt_pkg::EV_START_BYTE;
    sb_b   = '0;
    cmd_o  = '0;
    case (mode_q)
      xtt_pkg::MODE_TAG_OPEN, xtt_pkg::MODE_NAME: begin
        pv        = (mode_q == xtt_pkg::MODE_NAME) && pend_q;
        qc        = (mode_q == xtt_pkg::MODE_NAME) ? quote_q : '0;
        cmd_o.clr = (mode_q == xtt_pkg::MODE_TAG_OPEN);
        if (mode_q == xtt_pkg::MODE_TAG_OPEN &&
            (byte_i == xtt_pkg::CH_QM || byte_i == xtt_pkg::CH_SL)) begin
          sb_v = 1'b0;
        end else if (qc != '0) begin
          sb_v = 1'b1;
          sb_b = byte_i;
        end else if (byte_i == xtt_pkg::CH_GT) begin
          sb_v         = 1'b1;
          sb_ev        = xtt_pkg::EV_START_END;
          cmd_o.replay = pv;
        end else begin
          sa_v = pv;
          if (xtt_pkg::is_ws(byte_i)) begin
            sb_v  = 1'b1;
            sb_ev = xtt_pkg::EV_START_END;
          end else if (byte_i != xtt_pkg::CH_SL) begin
            sb_v = 1'b1;
            sb_b = byte_i;
          end
        end
      end
      xtt_pkg::MODE_ATTR: begin
        cmd_o.replay = (byte_i == xtt_pkg::CH_GT) && (prev_q == xtt_pkg::CH_SL);
      end
      xtt_pkg::MODE_CLOSE: begin
        sb_v = 1'b1;
        if (byte_i == xtt_pkg::CH_GT) begin
          sb_ev = xtt_pkg::EV_STOP_END;
        end else begin
          sb_ev = xtt_pkg::EV_STOP_BYTE;
          sb_b  = byte_i;
        end
      end
      xtt_pkg::MODE_VALUE_LEAD: begin
        if (byte_i != xtt_pkg::CH_LT && !xtt_pkg::is_ws(byte_i)) begin
          sb_v  = 1'b1;
          sb_ev = xtt_pkg::EV_VALUE_BYTE;
          sb_b  = byte_i;
        end
      end
      xtt_pkg::MODE_VALUE: begin
        sb_v = 1'b1;
        if (byte_i == xtt_pkg::CH_LT) begin
          sb_ev = xtt_pkg::EV_VALUE_END;
        end else begin
          sb_ev = xtt_pkg::EV_VALUE_BYTE;
          sb_b  = byte_i;
        end
      end
      default: begin
        sb_v = 1'b0;
      end
    endcase

    // held-back slash goes first
    if (sa_v) begin
      cmd_o.e0_v    = 1'b1;
      cmd_o.e0_ev   = xtt_pkg::EV_START_BYTE;
      cmd_o.e0_byte = xtt_pkg::CH_SL;
      cmd_o.e1_v    = sb_v;
      cmd_o.e1_ev   = sb_ev;
      cmd_o.e1_byte = sb_b;
    end else begin
      cmd_o.e0_v    = sb_v;
      cmd_o.e0_ev   = sb_ev;
      cmd_o.e0_byte = sb_b;
      cmd_o.e1_ev   = xtt_pkg::EV_START_BYTE;
    end

    // open value closed by end of data
    if (eod_i && mode_nx == xtt_pkg::MODE_VALUE) begin
      if (cmd_o.e0_v) begin
        cmd_o.e1_v    = 1'b1;
        cmd_o.e1_ev   = xtt_pkg::EV_VALUE_END;
        cmd_o.e1_byte = '0;
      end else begin
        cmd_o.e0_v    = 1'b1;
        cmd_o.e0_ev   = xtt_pkg::EV_VALUE_END;
        cmd_o.e0_byte = '0;
      end
    end

    cmd_push_o = acc_i && (cmd_o.e0_v || cmd_o.replay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= xtt_pkg::MODE_SEARCH;
      pend_q  <= 1'b0;
      quote_q <= '0;
      prev_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      quote_q <= quote_d;
      prev_q  <= prev_d;
    end
  end

endmodule

FILE: hdl/xtt_back.sv
`timescale 1ns / 1ps

module xtt_back #(
  parameter int NAME_MAX = xtt_pkg::NAME_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xtt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [2:0]    event_res_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);

  localparam int AW = $clog2(NAME_MAX);
  localparam int LW = $clog2(NAME_MAX + 1);

  xtt_pkg::phase_e phase_q, phase_d;
  xtt_pkg::cmd_t   cur_q, cur_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   len_q, len_d;
  logic [7:0]      name_mem [NAME_MAX];
  logic [7:0]      rd_data_q;

  logic            res_valid_q, res_valid_d;
  xtt_pkg::event_e res_ev_q;
  logic [7:0]      res_byte_q;
  logic            res_last_q;

  logic            adv, done, wr_en, load;
  xtt_pkg::event_e cur_ev;
  logic [7:0]      cur_byte;

  assign adv = (phase_q != xtt_pkg::PH_IDLE) && (!res_valid_q || pop_i);

  // current beat
  always_comb begin
    cur_ev   = xtt_pkg::EV_STOP_END;
    cur_byte = '0;
    done     = 1'b0;
    case (phase_q)
      xtt_pkg::PH_E0: begin
        cur_ev   = cur_q.e0_ev;
        cur_byte = cur_q.e0_byte;
        done     = !cur_q.e1_v && !cur_q.replay;
      end
      xtt_pkg::PH_E1: begin
        cur_ev   = cur_q.e1_ev;
        cur_byte = cur_q.e1_byte;
        done     = !cur_q.replay;
      end
      xtt_pkg::PH_REPLAY: begin
        if (idx_q < len_q) begin
          cur_ev   = xtt_pkg::EV_STOP_BYTE;
          cur_byte = rd_data_q;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
    wr_en     = adv && (cur_ev == xtt_pkg::EV_START_BYTE) && (len_q < LW'(NAME_MAX));
    load      = cmd_valid_i && ((phase_q == xtt_pkg::PH_IDLE) || (adv && done));
    cmd_pop_o = load;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    if (adv) begin
      case (phase_q)
        xtt_pkg::PH_E0: begin
          if (cur_q.e1_v) begin
            phase_d = xtt_pkg::PH_E1;
          end else if (cur_q.replay) begin
            phase_d = xtt_pkg::PH_REPLAY;
          end else begin
            phase_d = xtt_pkg::PH_IDLE;
          end
        end
        xtt_pkg::PH_E1: begin
          phase_d = cur_q.replay ? xtt_pkg::PH_REPLAY : xtt_pkg::PH_IDLE;
        end
        xtt_pkg::PH_REPLAY: begin
          phase_d = done ? xtt_pkg::PH_IDLE : xtt_pkg::PH_REPLAY;
        end
        default: begin
          phase_d = xtt_pkg::PH_IDLE;
        end
      endcase
    end
    if (load) begin
      if (cmd_i.e0_v) begin
        phase_d = xtt_pkg::PH_E0;
      end else if (cmd_i.e1_v) begin
        phase_d = xtt_pkg::PH_E1;
      end else begin
        phase_d = xtt_pkg::PH_REPLAY;
      end
    end
  end

  always_comb begin
    cur_d = load ? cmd_i : cur_q;

    if (load || phase_q != xtt_pkg::PH_REPLAY) begin
      idx_d = '0;
    end else if (adv) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end

    len_d = len_q;
    if (wr_en) begin
      len_d = len_q + 1'b1;
    end
    if (load && cmd_i.clr) begin
      len_d = '0;
    end

    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xtt_pkg::PH_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (adv) begin
      res_ev_q   <= cur_ev;
      res_byte_q <= cur_byte;
      res_last_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[len_q[AW-1:0]] <= cur_byte;
    end
    rd_data_q <= name_mem[idx_d[AW-1:0]];
  end

  assign empty_o     = !res_valid_q;
  assign event_res_o = res_ev_q;
  assign out_byte_o  = res_byte_q;
  assign last_o      = res_last_q;

endmodule

FILE: test/tokenizer_checker.sv
`timescale 1ns / 1ps

module tokenizer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [2:0] event_res_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  output int         err_count_o,
  output int         pending_o,
  output int         events_o,
  output int         replays_o
);

  import xtt_pkg::*;

  localparam int NAME_LEN = NAME_MAX_DEF;

  typedef struct {
    event_e     ev;
    logic [7:0] data;
    logic       fin;
  } token_t;

  token_t     exp_events[$];
  token_t     beat_events[$];

  mode_e      mode;
  logic [7:0] held_byte;
  logic       held_slash;
  logic [7:0] quote;
  logic [7:0] last_in;
  logic [7:0] names [NAME_LEN];
  int         name_cnt;
  logic       in_value;

  function automatic logic blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF);
  endfunction

  task automatic emit(input event_e ev, input logic [7:0] b);
    token_t t;
    t.ev   = ev;
    t.data = b;
    t.fin  = 1'b0;
    beat_events.push_back(t);
  endtask

  task automatic name_byte(input logic [7:0] b);
    emit(EV_START_BYTE, b);
    if (name_cnt < NAME_LEN) begin
      names[name_cnt] = b;
      name_cnt++;
    end
  endtask

  task automatic replay_name();
    for (int i = 0; i < name_cnt; i++) emit(EV_STOP_BYTE, names[i]);
    emit(EV_STOP_END, 8'h00);
    replays_o++;
  endtask

  task automatic clear_state();
    mode       = MODE_SEARCH;
    held_byte  = 8'h00;
    held_slash = 1'b0;
    quote      = 8'h00;
    last_in    = 8'h00;
    name_cnt   = 0;
    in_value   = 1'b0;
  endtask

  task automatic name_char(input logic [7:0] b);
    mode = MODE_NAME;
    if (quote != 8'h00) begin
      name_byte(b);
      if (b == quote) quote = 8'h00;
    end else if (b == CH_GT) begin
      emit(EV_START_END, 8'h00);
      if (held_slash) begin
        replay_name();
        mode = MODE_SEARCH;
      end else begin
        mode = MODE_VALUE_LEAD;
      end
      held_slash = 1'b0;
      held_byte  = 8'h00;
    end else begin
      // a slash not followed by '>' belongs to the name after all
      if (held_slash) begin
        name_byte(held_byte);
        held_slash = 1'b0;
        held_byte  = 8'h00;
      end
      if (blank(b)) begin
        emit(EV_START_END, 8'h00);
        mode = MODE_ATTR;
      end else if (b == CH_SL) begin
        held_byte  = CH_SL;
        held_slash = 1'b1;
      end else begin
        name_byte(b);
        if (b == CH_SQ || b == CH_DQ) quote = b;
      end
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic eod);
    beat_events.delete();
    case (mode)
      MODE_TAG_OPEN: begin
        name_cnt   = 0;
        held_slash = 1'b0;
        held_byte  = 8'h00;
        quote      = 8'h00;
        if (b == CH_QM) mode = MODE_HDR;
        else if (b == CH_SL) mode = MODE_CLOSE;
        else name_char(b);
      end
      MODE_HDR: begin
        if (b == CH_QM) mode = MODE_HDR_AFTER;
      end
      MODE_HDR_AFTER: mode = MODE_SEARCH;
      MODE_NAME: name_char(b);
      MODE_ATTR: begin
        if (b == CH_GT) begin
          if (last_in == CH_SL) begin
            replay_name();
            mode = MODE_SEARCH;
          end else begin
            mode = MODE_VALUE_LEAD;
          end
        end
      end
      MODE_CLOSE: begin
        if (b == CH_GT) begin
          emit(EV_STOP_END, 8'h00);
          mode = (last_in != CH_SL) ? MODE_VALUE_LEAD : MODE_SEARCH;
        end else begin
          emit(EV_STOP_BYTE, b);
        end
      end
      MODE_VALUE_LEAD: begin
        if (b == CH_LT) begin
          mode = MODE_TAG_OPEN;
        end else if (!blank(b)) begin
          emit(EV_VALUE_BYTE, b);
          in_value = 1'b1;
          mode     = MODE_VALUE;
        end
      end
      MODE_VALUE: begin
        if (b == CH_LT) begin
          emit(EV_VALUE_END, 8'h00);
          in_value = 1'b0;
          mode     = MODE_TAG_OPEN;
        end else begin
          emit(EV_VALUE_BYTE, b);
        end
      end
      default: begin
        mode = MODE_SEARCH;
        if (b == CH_LT) mode = MODE_TAG_OPEN;
        else if (b == CH_GT && last_in != CH_SL) mode = MODE_VALUE_LEAD;
      end
    endcase
    last_in = b;
    if (eod) begin
      if (in_value) emit(EV_VALUE_END, 8'h00);
      clear_state();
    end
    if (beat_events.size() > 0) beat_events[beat_events.size() - 1].fin = 1'b1;
    foreach (beat_events[i]) exp_events.push_back(beat_events[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      clear_state();
      exp_events.delete();
      err_count_o = 0;
      events_o    = 0;
      replays_o   = 0;
    end else begin
      if (push_i && !full_i) tokenize_byte(in_byte_i, end_of_data_i);
      if (pop_i && !empty_i) begin
        events_o++;
        if (exp_events.size() == 0) begin
          if (err_count_o < 10)
            $display("unexpected beat: ev %0d byte %02h last %0d",
                     event_res_i, out_byte_i, last_i);
          err_count_o++;
        end else begin
          want = exp_events.pop_front();
          if (event_res_i !== want.ev || out_byte_i !== want.data || last_i !== want.fin) begin
            if (err_count_o < 10)
              $display("mismatch: expected ev %0d byte %02h last %0d, got ev %0d byte %02h last %0d",
                       want.ev, want.data, want.fin, event_res_i, out_byte_i, last_i);
            err_count_o++;
          end
        end
      end
    end
    pending_o = exp_events.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import xtt_pkg::*;

  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_EQ = 8'h3D;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       pop         = 1'b0;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_data = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] event_res;
  logic [7:0] out_byte;
  logic       last;

  int         err_count;
  int         pending;
  int         events_seen;
  int         replays;
  int         sent        = 0;
  int         full_stalls = 0;
  logic       no_idle     = 1'b0;
  logic       hold        = 1'b0;

  always #2 clk_i = ~clk_i;

  xml_tag_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte),
    .end_of_data_i (end_of_data),
    .empty         (empty),
    .pop           (pop),
    .event_res_o   (event_res),
    .out_byte_o    (out_byte),
    .last_o        (last)
  );

  tokenizer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .in_byte_i     (in_byte),
    .end_of_data_i (end_of_data),
    .empty_i       (empty),
    .pop_i         (pop),
    .event_res_i   (event_res),
    .out_byte_i    (out_byte),
    .last_i        (last),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .events_o      (events_seen),
    .replays_o     (replays)
  );

  task automatic send(input logic [7:0] b, input logic eod);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push        <= 1'b1;
    in_byte     <= b;
    end_of_data <= eod;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    sent++;
  endtask

  task automatic send_str(input string s, input logic eod_last);
    for (int i = 0; i < s.len(); i++) send(s[i], eod_last && (i == s.len() - 1));
  endtask

  task automatic put_byte(input logic [7:0] b);
    send(b, $urandom_range(0, 39) == 0);
  endtask

  function automatic logic [7:0] letter();
    return CH_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] ws_pick();
    case ($urandom_range(0, 2))
      0:       return CH_SP;
      1:       return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  task automatic random_piece();
    int         len;
    logic [7:0] q;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        put_byte(CH_LT);
        put_byte(CH_QM);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) put_byte(letter());
        put_byte(CH_QM);
        put_byte(8'($urandom_range(0, 255)));
      end
      1, 2, 3: begin
        put_byte(CH_LT);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0) begin
            q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
            put_byte(q);
            put_byte(letter());
            put_byte($urandom_range(0, 1) ? CH_GT : ws_pick());
            put_byte(q);
          end else if ($urandom_range(0, 15) == 0) begin
            put_byte(CH_SL);
          end else begin
            put_byte(letter());
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          put_byte(ws_pick());
          put_byte(letter());
          put_byte(CH_EQ);
          put_byte(CH_DQ);
          put_byte(letter());
          put_byte(CH_DQ);
        end
        if ($urandom_range(0, 2) == 0) put_byte(CH_SL);
        put_byte(CH_GT);
      end
      4, 5: begin
        put_byte(CH_LT);
        put_byte(CH_SL);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) put_byte(letter());
        put_byte(CH_GT);
      end
      6, 7: begin
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) put_byte(ws_pick());
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          b = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : letter();
          put_byte(b == CH_LT ? letter() : b);
        end
      end
      8: begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
      end
      default: put_byte(CH_GT);
    endcase
  endtask

  // receiver side
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold) begin
        pop <= 1'b0;
      end else if (no_idle) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (sent >= 80);
    hold = 1'b1;
    repeat (150) @(posedge clk_i);
    hold = 1'b0;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_str("<?h?x<a/b> v</a><'>'/>>z", 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send_str("<b k/>", 1'b0);

    while (sent < 405) begin
      if (sent >= 345) no_idle = 1'b1;
      random_piece();
    end
    @(negedge clk_i);
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run: %0d text bytes, %0d event beats checked, %0d empty-tag replays",
             sent, events_seen, replays);
    $display("run: input held off by full for %0d cycles", full_stalls);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
